[design/jsesc_pkg.sv]
// Shared types, codes and the CP850 upper-half table for the JSON string escaper.
package jsesc_pkg;

    localparam logic [1:0] OPC_OPEN  = 2'd0;
    localparam logic [1:0] OPC_CHAR  = 2'd1;
    localparam logic [1:0] OPC_CLOSE = 2'd2;

    localparam int MAX_RUN = 6;
    localparam int RUN_W   = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CTRL_END  = 8'h20;
    localparam logic [15:0] CP_3BYTE = 16'h0800;
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] CONT      = 8'h80;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_word_t;

    // One queued run: its byte count and the bytes, first byte at index 0.
    typedef struct packed {
        logic [RUN_W-1:0]          len;
        logic [MAX_RUN-1:0][7:0]   bytes;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [15:0] CP850_UPPER [0:127] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00F8, 16'h00A3, 16'h00D8, 16'h00D7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h00AE, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h00C0,
        16'h00A9, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h00A2, 16'h00A5, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h00E3, 16'h00C3,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
        16'h00F0, 16'h00D0, 16'h00CA, 16'h00CB, 16'h00C8, 16'h0131, 16'h00CD, 16'h00CE,
        16'h00CF, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h00A6, 16'h00CC, 16'h2580,
        16'h00D3, 16'h00DF, 16'h00D4, 16'h00D2, 16'h00F5, 16'h00D5, 16'h00B5, 16'h00FE,
        16'h00DE, 16'h00DA, 16'h00DB, 16'h00D9, 16'h00FD, 16'h00DD, 16'h00AF, 16'h00B4,
        16'h00AD, 16'h00B1, 16'h2017, 16'h00BE, 16'h00B6, 16'h00A7, 16'h00F7, 16'h00B8,
        16'h00B0, 16'h00A8, 16'h00B7, 16'h00B9, 16'h00B3, 16'h00B2, 16'h25A0, 16'h00A0
    };

    function automatic logic [7:0] hex_lower(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            r = CH_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

[design/jsesc_front.sv]
// Front end: accepts input words and expands each but the unused opcode into a run of bytes.
module jsesc_front (
    input  logic                 item_valid,
    output logic                 item_ready,
    input  jsesc_pkg::in_word_t  item_data,
    input  jsesc_pkg::q_stat_t   q_stat,
    output logic                 push,
    output jsesc_pkg::run_t      run
);

    logic [7:0]  c;
    logic [15:0] cp;
    logic        has_run;

    assign c          = item_data.char_code;
    assign cp         = jsesc_pkg::CP850_UPPER[c[6:0]];
    assign item_ready = !q_stat.full;
    assign push       = item_valid && item_ready && has_run;

    always_comb
    begin
        run.len   = 3'd1;
        run.bytes = '0;
        has_run   = 1'b1;
        unique case (item_data.opcode) inside
            jsesc_pkg::OPC_OPEN, jsesc_pkg::OPC_CLOSE:
            begin
                run.bytes[0] = jsesc_pkg::CH_QUOTE;
            end
            jsesc_pkg::OPC_CHAR:
            begin
                if (c == jsesc_pkg::CH_QUOTE || c == jsesc_pkg::CH_BSLASH)
                begin
                    run.len      = 3'd2;
                    run.bytes[0] = jsesc_pkg::CH_BSLASH;
                    run.bytes[1] = c;
                end
                else if (c == jsesc_pkg::CH_LF || c == jsesc_pkg::CH_CR
                         || c == jsesc_pkg::CH_TAB)
                begin
                    run.len      = 3'd2;
                    run.bytes[0] = jsesc_pkg::CH_BSLASH;
                    run.bytes[1] = (c == jsesc_pkg::CH_LF) ? jsesc_pkg::CH_N :
                                   (c == jsesc_pkg::CH_CR) ? jsesc_pkg::CH_R :
                                   jsesc_pkg::CH_T;
                end
                else if (c < jsesc_pkg::CTRL_END)
                begin
                    run.len      = 3'd6;
                    run.bytes[0] = jsesc_pkg::CH_BSLASH;
                    run.bytes[1] = jsesc_pkg::CH_U;
                    run.bytes[2] = jsesc_pkg::CH_ZERO;
                    run.bytes[3] = jsesc_pkg::CH_ZERO;
                    run.bytes[4] = jsesc_pkg::hex_lower(c[7:4]);
                    run.bytes[5] = jsesc_pkg::hex_lower(c[3:0]);
                end
                else if (!c[7])
                begin
                    run.bytes[0] = c;
                end
                else if (cp < jsesc_pkg::CP_3BYTE)
                begin
                    run.len      = 3'd2;
                    run.bytes[0] = jsesc_pkg::LEAD2 | {3'd0, cp[10:6]};
                    run.bytes[1] = jsesc_pkg::CONT | {2'd0, cp[5:0]};
                end
                else
                begin
                    run.len      = 3'd3;
                    run.bytes[0] = jsesc_pkg::LEAD3 | {4'd0, cp[15:12]};
                    run.bytes[1] = jsesc_pkg::CONT | {2'd0, cp[11:6]};
                    run.bytes[2] = jsesc_pkg::CONT | {2'd0, cp[5:0]};
                end
            end
            default:
            begin
                // The unused opcode is taken and dropped.
                has_run = 1'b0;
            end
        endcase
    end

endmodule

[design/jsesc_queue.sv]
// Short queue of expanded runs between the front end and the byte sender.
module jsesc_queue #(
    parameter int DEPTH = jsesc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jsesc_pkg::run_t     push_run,
    input  logic                pop,
    output jsesc_pkg::run_t     head,
    output jsesc_pkg::q_stat_t  q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsesc_pkg::run_t   mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/jsesc_back.sv]
// Back end: walks the head run into the output register one byte per unstalled cycle.
module jsesc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  jsesc_pkg::run_t     head,
    input  jsesc_pkg::q_stat_t  q_stat,
    output logic                pop,
    output logic                sym_valid,
    input  logic                sym_ready,
    output jsesc_pkg::out_word_t sym_data
);

    logic [jsesc_pkg::RUN_W-1:0] idx_reg, idx_next;
    logic                        valid_reg, valid_next;
    jsesc_pkg::out_word_t        data_reg;
    logic                        load;
    logic                        fire;
    logic                        head_last;

    assign sym_valid = valid_reg;
    assign sym_data  = data_reg;

    always_comb
    begin
        head_last  = (idx_reg == head.len - 1'b1);
        load       = !valid_reg || sym_ready;
        fire       = load && !q_stat.empty;
        pop        = fire && head_last;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
            idx_next   = head_last ? '0 : idx_reg + 1'b1;
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg.out_byte    <= head.bytes[idx_reg];
            data_reg.last_of_run <= head_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[design/json_string_escape_cp850.sv]
// A run is queued, then its first byte is loaded into the output register.
// Input words are taken one per cycle while each yields one byte and the
// output is not stalled; a word of n bytes is sent one byte at a time.
// The run queue lets input be taken while the output is stalled, until full.
// Reset (rst_n low, asynchronous) empties the queue and drops the output valid.
module json_string_escape_cp850 #(
    parameter int QUEUE_DEPTH = jsesc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  jsesc_pkg::in_word_t  item_data,
    output logic                 sym_valid,
    input  logic                 sym_ready,
    output jsesc_pkg::out_word_t sym_data
);

    jsesc_pkg::q_stat_t q_stat;
    jsesc_pkg::run_t    push_run;
    jsesc_pkg::run_t    head;
    logic               push;
    logic               pop;

    jsesc_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .q_stat     (q_stat),
        .push       (push),
        .run        (push_run)
    );

    jsesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    jsesc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym_data  (sym_data)
    );

endmodule

[design/jsesc_checker.sv]
// Port-level checks for the JSON string escaper, bound to the top level.
module jsesc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 sym_valid,
    input logic                 sym_ready,
    input jsesc_pkg::out_word_t sym_data
);

    // Output valid is cleared by reset and is still low at the edge after one in reset.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !sym_valid)
        else $error("output word valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_ready |=> sym_valid && $stable(sym_data))
        else $error("stalled output word changed or dropped");

    // A quote only ever ends a run: open, close or the second byte of an escape.
    a_quote_last: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_data.out_byte == jsesc_pkg::CH_QUOTE |-> sym_data.last_of_run)
        else $error("quote word not marked last of run");

    // A UTF-8 lead byte always has continuation bytes after it.
    a_prefix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_data.out_byte[7:6] == 2'b11 |-> !sym_data.last_of_run)
        else $error("prefix word marked last of run");

    // After a word that does not end its run, the next output word follows.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_ready && !sym_data.last_of_run |=> sym_valid)
        else $error("gap inside a run");

endmodule

bind json_string_escape_cp850 jsesc_checker u_jsesc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .sym_valid  (sym_valid),
    .sym_ready  (sym_ready),
    .sym_data   (sym_data)
);
